@@ rtl/core/nps_pkg.sv @@
package nps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int ID_W   = 4;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 112;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
  } result_t;

  typedef struct packed {
    logic load;
    logic init;
    logic scan;
    logic swap;
    logic commit;
    logic acc;
    logic div_start;
    logic out_rd;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic scan_last;
    logic slot_last;
    logic div_busy;
    logic out_fire;
    logic out_last;
  } sts_t;

endpackage

@@ rtl/core/nonpreemptive_priority_scheduler.sv @@
// Non-preemptive priority scheduler.
// Input stream: one item per process, tdata = arrival time, burst time and
// priority; tlast marks the final process and starts the schedule. Up to
// MAX_PROCS processes are held; items beyond that are dropped, but a dropped
// item with tlast still starts the schedule.
// Loading takes one item per cycle. After the tlast item, tready stays low
// while the table is scheduled: each slot i after the first scans entries
// i..n-1 through the single read port of the process table (the first slot
// reads only entry 0), then passes through the drain, swap, commit and
// accumulate states. Two shift-subtract dividers then compute the averages.
// Output stream: one item per process in schedule order, each read from the
// result table and registered, the next one only after the previous one is
// taken; tlast marks the final result. A stalled receiver holds the output
// register and the sequence; nothing is lost.
// After the final result is taken the block returns to loading with an empty
// table. Reset returns the block to loading with an empty table.
module nonpreemptive_priority_scheduler import nps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] arrival_time, [31:16] burst_time, [39:32] priority_level
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [3:0] process_id, [24:4] completion_time, [45:25] turnaround_time,
  // [66:46] waiting_time, [87:67] average_turnaround, [108:88] average_waiting
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  nps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  nps_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ rtl/core/nps_div.sv @@
module nps_div import nps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W:0]    trial;
  logic              ge;

  always_comb begin
    trial  = {rem_q, quo_q[SUM_W-1]};
    ge     = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[SUM_W-2:0], ge};
      rem_d  = ge ? CNT_W'(trial - {1'b0, dsr_q}) : CNT_W'(trial);
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/nps_ctrl.sv @@
module nps_ctrl import nps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_LOAD     = 4'd0;
  localparam logic [3:0] ST_SCAN     = 4'd1;
  localparam logic [3:0] ST_DRAIN    = 4'd2;
  localparam logic [3:0] ST_SWAP     = 4'd3;
  localparam logic [3:0] ST_COMMIT   = 4'd4;
  localparam logic [3:0] ST_ACC      = 4'd5;
  localparam logic [3:0] ST_DIV      = 4'd6;
  localparam logic [3:0] ST_DIV_WAIT = 4'd7;
  localparam logic [3:0] ST_OUT_RD   = 4'd8;
  localparam logic [3:0] ST_OUT_LD   = 4'd9;
  localparam logic [3:0] ST_OUT_WAIT = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (sts_i.in_last) begin
          cmd_o.init = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_SWAP;
      end
      ST_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.slot_last ? ST_DIV : ST_SCAN;
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd_o.out_ld = 1'b1;
        state_d      = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (sts_i.out_fire) begin
          state_d = sts_i.out_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/nps_datapath.sv @@
module nps_datapath import nps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  entry_t  tab_mem [MAX_PROCS];
  result_t res_mem [MAX_PROCS];

  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  last_idx, scan_end;
  logic [IDX_W-1:0]  slot_q, scan_q, rj_q, best_q, k_q;
  logic              rv_q, found_q;
  entry_t            rd_q, slot_ent_q, best_ent_q, sel_ent;
  logic [IDX_W-1:0]  sel_idx;
  logic [TIME_W-1:0] prev_q, comp_q, start, tat, wt;
  logic [TIME_W:0]   fin;
  logic [ARR_W:0]    ab_q;
  logic [TIME_W-1:0] tat_q, wt_q;
  logic [SUM_W-1:0]  tsum_q, wsum_q;
  logic [SUM_W:0]    tsum_add, wsum_add;
  logic              arrived, better;
  logic              in_fire, out_fire;
  logic              tab_we;
  logic [IDX_W-1:0]  tab_wa;
  entry_t            tab_wd, in_ent;
  result_t           rr_q;
  logic              busy_t, busy_w;
  logic [SUM_W-1:0]  avg_t, avg_w;
  logic              out_valid_q;
  logic              out_last_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign in_fire  = s_axis_tvalid & cmd_i.load;
  assign out_fire = out_valid_q & m_axis_tready;
  assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
  assign scan_end = (slot_q == '0) ? slot_q : last_idx;

  assign in_ent.arrival = s_axis_tdata[15:0];
  assign in_ent.burst   = s_axis_tdata[31:16];
  assign in_ent.prio    = s_axis_tdata[39:32];
  assign in_ent.id      = ID_W'(cnt_q);

  assign arrived = {{(TIME_W-ARR_W){1'b0}}, rd_q.arrival} <= prev_q;
  assign better  = !found_q || (rd_q.prio < best_ent_q.prio);
  assign sel_idx = found_q ? best_q : slot_q;
  assign sel_ent = found_q ? best_ent_q : slot_ent_q;

  assign start = (prev_q > TIME_W'(sel_ent.arrival)) ? prev_q : TIME_W'(sel_ent.arrival);
  assign fin   = {1'b0, start} + (TIME_W+1)'(sel_ent.burst);
  assign tat   = comp_q - TIME_W'(sel_ent.arrival);
  assign wt    = comp_q - TIME_W'(ab_q);

  assign tsum_add = {1'b0, tsum_q} + (SUM_W+1)'(tat_q);
  assign wsum_add = {1'b0, wsum_q} + (SUM_W+1)'(wt_q);

  always_comb begin
    tab_we = 1'b0;
    tab_wa = cnt_q[IDX_W-1:0];
    tab_wd = in_ent;
    priority if (in_fire) begin
      tab_we = cnt_q < CNT_W'(MAX_PROCS);
    end else if (cmd_i.swap) begin
      tab_we = 1'b1;
      tab_wa = sel_idx;
      tab_wd = slot_ent_q;
    end else if (cmd_i.commit) begin
      tab_we = 1'b1;
      tab_wa = slot_q;
      tab_wd = sel_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
    if (cmd_i.scan) begin
      rd_q <= tab_mem[scan_q];
    end
    if (cmd_i.commit) begin
      res_mem[slot_q] <= '{id: sel_ent.id, completion: comp_q, turnaround: tat, waiting: wt};
    end
    if (cmd_i.out_rd) begin
      rr_q <= res_mem[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      tsum_q      <= '0;
      wsum_q      <= '0;
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      scan_q      <= '0;
      k_q         <= '0;
    end else begin
      rv_q <= cmd_i.scan;
      if (in_fire && (cnt_q < CNT_W'(MAX_PROCS))) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.init) begin
        slot_q  <= '0;
        scan_q  <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (rv_q && arrived && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.acc) begin
        tsum_q <= tsum_add[SUM_W] ? SUM_MAX : tsum_add[SUM_W-1:0];
        wsum_q <= wsum_add[SUM_W] ? SUM_MAX : wsum_add[SUM_W-1:0];
        if (slot_q != last_idx) begin
          slot_q  <= slot_q + IDX_W'(1);
          scan_q  <= slot_q + IDX_W'(1);
          found_q <= 1'b0;
        end
      end
      if (cmd_i.div_start) begin
        k_q <= '0;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
        if (out_last_q) begin
          cnt_q  <= '0;
          tsum_q <= '0;
          wsum_q <= '0;
        end else begin
          k_q <= k_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      prev_q <= '0;
    end else if (cmd_i.commit) begin
      prev_q <= comp_q;
    end
    if (rv_q) begin
      if (rj_q == slot_q) begin
        slot_ent_q <= rd_q;
      end
      if (arrived && better) begin
        best_q     <= rj_q;
        best_ent_q <= rd_q;
      end
    end
    rj_q <= scan_q;
    if (cmd_i.swap) begin
      comp_q <= fin[TIME_W] ? TIME_MAX : fin[TIME_W-1:0];
      ab_q   <= {1'b0, sel_ent.arrival} + (ARR_W+1)'(sel_ent.burst);
    end
    if (cmd_i.commit) begin
      tat_q <= tat;
      wt_q  <= wt;
    end
    if (cmd_i.out_ld) begin
      out_data_q <= {3'b000, avg_w[TIME_W-1:0], avg_t[TIME_W-1:0],
                     rr_q.waiting, rr_q.turnaround, rr_q.completion, rr_q.id};
      out_last_q <= k_q == last_idx;
    end
  end

  nps_div u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (tsum_q),
    .divisor_i  (cnt_q),
    .busy_o     (busy_t),
    .quotient_o (avg_t)
  );

  nps_div u_div_w (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (wsum_q),
    .divisor_i  (cnt_q),
    .busy_o     (busy_w),
    .quotient_o (avg_w)
  );

  assign sts_o.in_last   = s_axis_tvalid & s_axis_tlast;
  assign sts_o.scan_last = scan_q == scan_end;
  assign sts_o.slot_last = slot_q == last_idx;
  assign sts_o.div_busy  = busy_t | busy_w;
  assign sts_o.out_fire  = out_fire;
  assign sts_o.out_last  = out_last_q;

  assign s_axis_tready = cmd_i.load;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/core/nps_checker.sv @@
module nps_checker import nps_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic                  m_axis_tlast,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("loading while results pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input not held off after final process");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not back to loading after final result");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/testbench.sv @@
import nps_pkg::*;

typedef struct packed {
  bit [ID_W-1:0]   pid;
  bit [TIME_W-1:0] completion;
  bit [TIME_W-1:0] turnaround;
  bit [TIME_W-1:0] waiting;
  bit [TIME_W-1:0] avg_turnaround;
  bit [TIME_W-1:0] avg_waiting;
  bit              last;
} slot_result_t;

class schedule_checker;
  bit [ARR_W-1:0] arrival [MAX_PROCS];
  bit [BUR_W-1:0] burst [MAX_PROCS];
  bit [PRI_W-1:0] prio [MAX_PROCS];
  bit [ID_W-1:0]  pid [MAX_PROCS];
  int unsigned    loaded;
  slot_result_t   expected_slots [$];
  int unsigned    mismatches;

  function new();
    loaded = 0;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return expected_slots.size();
  endfunction

  function void note_process(bit [ARR_W-1:0] arr, bit [BUR_W-1:0] bur,
                             bit [PRI_W-1:0] pri, bit last);
    if (loaded < MAX_PROCS) begin
      arrival[loaded] = arr;
      burst[loaded]   = bur;
      prio[loaded]    = pri;
      pid[loaded]     = loaded[ID_W-1:0];
      loaded++;
    end
    if (last) plan_schedule();
  endfunction

  function void plan_schedule();
    int unsigned    done_at [MAX_PROCS];
    int unsigned    tat [MAX_PROCS];
    int unsigned    wt [MAX_PROCS];
    int unsigned    prev, best, start, tsum, wsum, n;
    bit [PRI_W-1:0] best_pri;
    bit             found;
    bit [ARR_W-1:0] ta;
    bit [BUR_W-1:0] tb;
    bit [PRI_W-1:0] tp;
    bit [ID_W-1:0]  ti;
    slot_result_t   r;
    n = loaded;
    for (int i = 0; i < n; i++) begin
      prev = (i == 0) ? 0 : done_at[i-1];
      if (i > 0) begin
        found = 1'b0;
        best = i;
        best_pri = '0;
        for (int j = i; j < n; j++) begin
          if (arrival[j] <= prev && (!found || prio[j] < best_pri)) begin
            found = 1'b1;
            best = j;
            best_pri = prio[j];
          end
        end
        ta = arrival[i]; arrival[i] = arrival[best]; arrival[best] = ta;
        tb = burst[i];   burst[i]   = burst[best];   burst[best]   = tb;
        tp = prio[i];    prio[i]    = prio[best];    prio[best]    = tp;
        ti = pid[i];     pid[i]     = pid[best];     pid[best]     = ti;
      end
      start = (prev > arrival[i]) ? prev : arrival[i];
      done_at[i] = start + burst[i];
      if (done_at[i] > TIME_MAX) done_at[i] = TIME_MAX;
    end
    tsum = 0;
    wsum = 0;
    for (int i = 0; i < n; i++) begin
      tat[i] = done_at[i] - arrival[i];
      wt[i]  = tat[i] - burst[i];
      tsum = tsum + tat[i];
      if (tsum > SUM_MAX) tsum = SUM_MAX;
      wsum = wsum + wt[i];
      if (wsum > SUM_MAX) wsum = SUM_MAX;
    end
    for (int i = 0; i < n; i++) begin
      r.pid            = pid[i];
      r.completion     = TIME_W'(done_at[i]);
      r.turnaround     = TIME_W'(tat[i]);
      r.waiting        = TIME_W'(wt[i]);
      r.avg_turnaround = TIME_W'(tsum / n);
      r.avg_waiting    = TIME_W'(wsum / n);
      r.last           = (i == n - 1);
      expected_slots.push_back(r);
    end
    loaded = 0;
  endfunction

  function void check_result(bit [OUT_DATA_W-1:0] data, bit last);
    slot_result_t got, want;
    got.pid            = data[3:0];
    got.completion     = data[24:4];
    got.turnaround     = data[45:25];
    got.waiting        = data[66:46];
    got.avg_turnaround = data[87:67];
    got.avg_waiting    = data[108:88];
    got.last           = last;
    if (expected_slots.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("extra result: id=%0d done=%0d tat=%0d wait=%0d avg_tat=%0d avg_wait=%0d last=%0b",
                 got.pid, got.completion, got.turnaround, got.waiting,
                 got.avg_turnaround, got.avg_waiting, got.last);
      return;
    end
    want = expected_slots.pop_front();
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected id=%0d done=%0d tat=%0d wait=%0d avg_tat=%0d avg_wait=%0d last=%0b",
                 want.pid, want.completion, want.turnaround, want.waiting,
                 want.avg_turnaround, want.avg_waiting, want.last);
        $display("  actual   id=%0d done=%0d tat=%0d wait=%0d avg_tat=%0d avg_wait=%0d last=%0b",
                 got.pid, got.completion, got.turnaround, got.waiting,
                 got.avg_turnaround, got.avg_waiting, got.last);
      end
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  bit steady;
  schedule_checker sched = new();

  nonpreemptive_priority_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (steady) return 0;
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned pick_value(int unsigned top, int unsigned window);
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 0;
    if (roll < 20) return top;
    if (roll < 60) return $urandom_range(window);
    return $urandom_range(top);
  endfunction

  task automatic feed_process(bit [ARR_W-1:0] arr, bit [BUR_W-1:0] bur,
                              bit [PRI_W-1:0] pri, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pri, bur, arr};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sched.note_process(arr, bur, pri, last);
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sched.check_result(m_axis_tdata, m_axis_tlast);
      if (stall == 0) stall = pick_gap();
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int          n, sent, roll;
    int unsigned span;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    steady        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone process at the field maxima
    feed_process(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    // idle gap before the second slot, then a priority tie
    feed_process(16'd0, 16'd0, 8'd0, 1'b0);
    feed_process(16'd10, 16'd3, 8'd7, 1'b0);
    feed_process(16'd1, 16'd4, 8'd7, 1'b0);
    feed_process(16'd2, 16'hFFFF, 8'hFF, 1'b0);
    feed_process(16'd1, 16'd1, 8'd7, 1'b1);
    // overfull set: the last two items are dropped, the final one still starts it
    for (int i = 0; i < 18; i++)
      feed_process(ARR_W'(pick_value(16'hFFFF, 200)), BUR_W'(pick_value(16'hFFFF, 50)),
                   PRI_W'(pick_value(8'hFF, 3)), i == 17);

    sent = 0;
    while (sent < 76) begin
      roll = $urandom_range(99);
      if (roll < 70)      n = $urandom_range(6, 1);
      else if (roll < 92) n = $urandom_range(16, 7);
      else                n = $urandom_range(20, 17);
      steady = ($urandom_range(9) == 0);
      span = ($urandom_range(3) == 0) ? 16'hFFFF : 30 * n;
      for (int i = 0; i < n; i++)
        feed_process(ARR_W'(pick_value(16'hFFFF, span)), BUR_W'(pick_value(16'hFFFF, 40)),
                     PRI_W'(pick_value(8'hFF, 7)), i == n - 1);
      sent += n;
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sched.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sched.mismatches == 0 && sched.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ nonpreemptive_priority_scheduler.f @@
rtl/core/nps_pkg.sv
rtl/core/nps_div.sv
rtl/core/nps_ctrl.sv
rtl/core/nps_datapath.sv
rtl/core/nonpreemptive_priority_scheduler.sv
rtl/core/nps_checker.sv
bench/testbench.sv
